[src/ssfe_pkg.sv]
`timescale 1ns / 1ps
package ssfe_pkg;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int CNT_W = 6;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 64;
   localparam logic [62:0] ENERGY_MAX = {63{1'b1}};

   typedef enum logic [CSR_AW-1:0] {
      CSR_RADIUS0      = 3'd0,
      CSR_START_TIME   = 3'd1,
      CSR_SHRINK_RATE  = 3'd2,
      CSR_STRENGTH     = 3'd3,
      CSR_CURRENT_TIME = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_RATE, MUL_XX, MUL_YY, MUL_ZZ, MUL_RR, MUL_SD, MUL_DD,
      MUL_FXL, MUL_FXH, MUL_FYL, MUL_FYH, MUL_FZL, MUL_FZH, MUL_ELO, MUL_EHI
   } mul_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RAD, S_SQX, S_SQY, S_SQZ, S_RR, S_RR_WAIT, S_CMP, S_SQRT,
      S_SD, S_DD, S_DIV, S_FXL, S_FXH, S_FYL, S_FYH, S_FZL, S_FZH, S_ACC,
      S_ELO, S_EHI, S_EWAIT, S_FIN
   } state_type;

   typedef struct packed {
      mul_op_type mul_op;
      logic       load_item;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_step;
      logic       latch_outside;
      logic       accum;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic outside;
      logic last;
   } status_type;

   // Opposite-signed, saturated increment from its 48-bit magnitude: negated when the coordinate is positive.
   function automatic logic [31:0] sat_incr(input logic [47:0] m, input logic p_pos);
      logic [31:0] v;
      if (p_pos) begin
         v = (m >= 48'h0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
      end else begin
         v = (m >= 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
      return v;
   endfunction

endpackage

[src/shrinking_shell_force_energy.sv]
`timescale 1ns / 1ps
// Shrinking spherical shell confinement: per-point force increments and batch energy.
// Points arrive as signed Q16.16 coordinates on the req_ channel (valid/ready); one
// result beat per point leaves on the rsp_ channel with the saturated increments,
// the outside flag and, on the point marked last, the batch energy (0.5*C*sum).
// Registers are written through csr_we/csr_addr/csr_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each point passes through the shrunk radius, the squared distance and the shell
// compare; a point outside then takes 32 square root steps and 64 divide steps on
// the iterative units and the force products, and a last point adds the energy.
// One point is in flight at a time; req_ready rises in the same cycle as rsp_valid,
// so a new point is taken while that result waits.
// A stalled receiver holds the result beat; the next point then finishes its work
// and waits until the output register frees.
// Reset (synchronous, active high) loads the register defaults (radius and strength
// 1.0, times and rate zero), clears the energy accumulator and drops rsp_valid.
module shrinking_shell_force_energy import ssfe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic                req_last_point,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_acc_dx,
   output logic signed [31:0]  rsp_acc_dy,
   output logic signed [31:0]  rsp_acc_dz,
   output logic                rsp_outside_shell,
   output logic [62:0]         rsp_batch_energy,
   output logic                rsp_batch_done
);

   cmd_type    cmd;
   status_type status;

   ssfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssfe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_last_point    (req_last_point),
      .cmd               (cmd),
      .status            (status),
      .rsp_acc_dx        (rsp_acc_dx),
      .rsp_acc_dy        (rsp_acc_dy),
      .rsp_acc_dz        (rsp_acc_dz),
      .rsp_outside_shell (rsp_outside_shell),
      .rsp_batch_energy  (rsp_batch_energy),
      .rsp_batch_done    (rsp_batch_done)
   );

   // Only one point is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new point taken while one is in flight");

   // A point inside the shell carries no increment.
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_outside_shell) |->
      (rsp_acc_dx == '0 && rsp_acc_dy == '0 && rsp_acc_dz == '0))
      else $error("inside point has a nonzero increment");

   // Energy is reported only on the last point of a batch.
   a_energy_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_batch_done) |-> (rsp_batch_energy == '0))
      else $error("energy reported on a point that is not last");

   // A result beat is loaded only into a free output register.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten");

endmodule

[src/ssfe_ctrl.sv]
`timescale 1ns / 1ps
module ssfe_ctrl import ssfe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cnt_in = (state_ff == S_SQRT || state_ff == S_DIV) ? cnt_ff + CNT_W'(1) : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_RAD;
         S_RAD:     state_in = S_SQX;
         S_SQX:     state_in = S_SQY;
         S_SQY:     state_in = S_SQZ;
         S_SQZ:     state_in = S_RR;
         S_RR:      state_in = S_RR_WAIT;
         S_RR_WAIT: state_in = S_CMP;
         S_CMP: begin
            priority if (status.outside) state_in = S_SQRT;
            else if (status.last)        state_in = S_ELO;
            else                         state_in = S_FIN;
         end
         S_SQRT:    if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = S_SD;
         S_SD:      state_in = S_DD;
         S_DD:      state_in = S_DIV;
         S_DIV:     if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_FXL;
         S_FXL:     state_in = S_FXH;
         S_FXH:     state_in = S_FYL;
         S_FYL:     state_in = S_FYH;
         S_FYH:     state_in = S_FZL;
         S_FZL:     state_in = S_FZH;
         S_FZH:     state_in = S_ACC;
         S_ACC:     state_in = status.last ? S_ELO : S_FIN;
         S_ELO:     state_in = S_EHI;
         S_EHI:     state_in = S_EWAIT;
         S_EWAIT:   state_in = S_FIN;
         S_FIN:     if (slot_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_op = MUL_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_RAD: cmd.mul_op = MUL_RATE;
         S_SQX: cmd.mul_op = MUL_XX;
         S_SQY: cmd.mul_op = MUL_YY;
         S_SQZ: cmd.mul_op = MUL_ZZ;
         S_RR:  cmd.mul_op = MUL_RR;
         S_CMP: begin
            cmd.latch_outside = 1'b1;
            cmd.sqrt_init     = 1'b1;
         end
         S_SQRT: cmd.sqrt_step = 1'b1;
         S_SD:   cmd.mul_op = MUL_SD;
         S_DD:   cmd.mul_op = MUL_DD;
         S_DIV:  cmd.div_step = 1'b1;
         S_FXL:  cmd.mul_op = MUL_FXL;
         S_FXH:  cmd.mul_op = MUL_FXH;
         S_FYL:  cmd.mul_op = MUL_FYL;
         S_FYH:  cmd.mul_op = MUL_FYH;
         S_FZL:  cmd.mul_op = MUL_FZL;
         S_FZH:  cmd.mul_op = MUL_FZH;
         S_ACC:  cmd.accum = 1'b1;
         S_ELO:  cmd.mul_op = MUL_ELO;
         S_EHI:  cmd.mul_op = MUL_EHI;
         S_FIN:  cmd.out_load = slot_free;
         default: cmd.mul_op = MUL_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/ssfe_dp.sv]
`timescale 1ns / 1ps
module ssfe_dp import ssfe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic                req_last_point,
   input  cmd_type             cmd,
   output status_type          status,
   output logic signed [31:0]  rsp_acc_dx,
   output logic signed [31:0]  rsp_acc_dy,
   output logic signed [31:0]  rsp_acc_dz,
   output logic                rsp_outside_shell,
   output logic [62:0]         rsp_batch_energy,
   output logic                rsp_batch_done
);

   logic [30:0] radius0_ff, strength_ff;
   logic [31:0] start_time_ff, shrink_rate_ff, current_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius0_ff      <= 31'd65536;
         start_time_ff   <= '0;
         shrink_rate_ff  <= '0;
         strength_ff     <= 31'd65536;
         current_time_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_RADIUS0:      radius0_ff      <= csr_wdata[30:0];
            CSR_START_TIME:   start_time_ff   <= csr_wdata;
            CSR_SHRINK_RATE:  shrink_rate_ff  <= csr_wdata;
            CSR_STRENGTH:     strength_ff     <= csr_wdata[30:0];
            CSR_CURRENT_TIME: current_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0] px_ff, py_ff, pz_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pz_ff   <= req_pos_z;
         last_ff <= req_last_point;
      end
   end

   logic [31:0] ax, ay, az;
   logic        px_pos, py_pos, pz_pos;

   assign ax = px_ff[31] ? (~px_ff + 32'd1) : px_ff;
   assign ay = py_ff[31] ? (~py_ff + 32'd1) : py_ff;
   assign az = pz_ff[31] ? (~pz_ff + 32'd1) : pz_ff;
   assign px_pos = !px_ff[31] && (px_ff != '0);
   assign py_pos = !py_ff[31] && (py_ff != '0);
   assign pz_pos = !pz_ff[31] && (pz_ff != '0);

   // Working registers.
   logic signed [51:0] r_ff;
   logic [63:0] rsq_ff, rr_ff, term_ff, part_ff, lo_ff;
   logic [34:0] sq_rem_ff;
   logic [63:0] sq_src_ff;
   logic [31:0] root_ff;
   logic [63:0] div_q_ff;
   logic [31:0] div_rem_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic [62:0] energy_ff;
   logic [63:0] energy_sum_ff;
   logic        outside_ff;

   logic signed [32:0] dt;
   logic [51:0] rabs, d_full;
   logic        rbig;
   logic [32:0] d;

   assign dt = {current_time_ff[31], current_time_ff} - {start_time_ff[31], start_time_ff};
   assign rabs = r_ff[51] ? (~r_ff + 52'd1) : r_ff;
   assign rbig = |rabs[51:32];
   assign d_full = {20'b0, root_ff} - r_ff;
   assign d = d_full[32:0];

   // Shared multiplier with a registered product.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   mul_op_type         prod_op_ff;

   always_comb begin
      unique case (cmd.mul_op)
         MUL_NONE: begin mul_a = '0; mul_b = '0; end
         MUL_RATE: begin
            mul_a = {{2{shrink_rate_ff[31]}}, shrink_rate_ff};
            mul_b = {dt[32], dt};
         end
         MUL_XX:  begin mul_a = {2'b00, ax}; mul_b = {2'b00, ax}; end
         MUL_YY:  begin mul_a = {2'b00, ay}; mul_b = {2'b00, ay}; end
         MUL_ZZ:  begin mul_a = {2'b00, az}; mul_b = {2'b00, az}; end
         MUL_RR:  begin mul_a = {2'b00, rabs[31:0]}; mul_b = {2'b00, rabs[31:0]}; end
         MUL_SD:  begin mul_a = {3'b000, strength_ff}; mul_b = {1'b0, d}; end
         MUL_DD:  begin mul_a = {2'b00, d[31:0]}; mul_b = {2'b00, d[31:0]}; end
         MUL_FXL: begin mul_a = {2'b00, div_q_ff[31:0]}; mul_b = {2'b00, ax}; end
         MUL_FXH: begin mul_a = {2'b00, div_q_ff[63:32]}; mul_b = {2'b00, ax}; end
         MUL_FYL: begin mul_a = {2'b00, div_q_ff[31:0]}; mul_b = {2'b00, ay}; end
         MUL_FYH: begin mul_a = {2'b00, div_q_ff[63:32]}; mul_b = {2'b00, ay}; end
         MUL_FZL: begin mul_a = {2'b00, div_q_ff[31:0]}; mul_b = {2'b00, az}; end
         MUL_FZH: begin mul_a = {2'b00, div_q_ff[63:32]}; mul_b = {2'b00, az}; end
         MUL_ELO: begin mul_a = {3'b000, strength_ff}; mul_b = {2'b00, energy_sum_ff[31:0]}; end
         MUL_EHI: begin mul_a = {3'b000, strength_ff}; mul_b = {2'b00, energy_sum_ff[63:32]}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_op_ff <= MUL_NONE;
      end else begin
         prod_op_ff <= cmd.mul_op;
      end
   end

   // Consumers of the registered product.
   logic signed [67:0] sh;
   logic [63:0] incr_sum;
   logic [47:0] incr_m;
   logic [63:0] hi;
   logic [63:0] en_sum;
   logic [62:0] en_val;

   assign sh = prod_ff >>> 16;
   assign incr_sum = part_ff + {prod_ff[31:0], 32'b0};
   assign incr_m = incr_sum[63:16];
   assign hi = prod_ff[63:0];
   assign en_sum = {1'b0, hi[47:0], 15'b0} + {17'b0, lo_ff[63:17]};
   assign en_val = ((|hi[63:48]) || en_sum[63]) ? ENERGY_MAX : en_sum[62:0];

   always_ff @(posedge clock) begin
      unique case (prod_op_ff)
         MUL_RATE: r_ff <= {21'b0, radius0_ff} - sh[51:0];
         MUL_XX:   rsq_ff <= prod_ff[63:0];
         MUL_YY:   rsq_ff <= rsq_ff + prod_ff[63:0];
         MUL_ZZ:   rsq_ff <= rsq_ff + prod_ff[63:0];
         MUL_RR:   rr_ff <= prod_ff[63:0];
         MUL_DD:   term_ff <= d[32] ? {64{1'b1}} : prod_ff[63:0];
         MUL_FXL, MUL_FYL, MUL_FZL, MUL_ELO: begin
            part_ff <= prod_ff[63:0];
            lo_ff   <= prod_ff[63:0];
         end
         MUL_FXH:  dx_ff <= sat_incr(incr_m, px_pos);
         MUL_FYH:  dy_ff <= sat_incr(incr_m, py_pos);
         MUL_FZH:  dz_ff <= sat_incr(incr_m, pz_pos);
         MUL_EHI:  energy_ff <= en_val;
         default: ;
      endcase
   end

   // Square root, one result bit per step.
   logic [34:0] sq_rem2, sq_trial;
   logic        sq_geq;

   assign sq_rem2 = {sq_rem_ff[32:0], sq_src_ff[63:62]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_geq = sq_rem2 >= sq_trial;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sq_rem_ff <= '0;
         root_ff   <= '0;
         sq_src_ff <= rsq_ff;
      end else if (cmd.sqrt_step) begin
         sq_rem_ff <= sq_geq ? (sq_rem2 - sq_trial) : sq_rem2;
         root_ff   <= {root_ff[30:0], sq_geq};
         sq_src_ff <= {sq_src_ff[61:0], 2'b00};
      end
   end

   // Restoring divider, one quotient bit per step.
   logic [32:0] dv_rem2, dv_diff;
   logic        dv_geq;

   assign dv_rem2 = {div_rem_ff, div_q_ff[63]};
   assign dv_diff = dv_rem2 - {1'b0, root_ff};
   assign dv_geq = dv_rem2 >= {1'b0, root_ff};

   always_ff @(posedge clock) begin
      if (prod_op_ff == MUL_SD) begin
         div_q_ff   <= prod_ff[63:0];
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_rem_ff <= dv_geq ? dv_diff[31:0] : dv_rem2[31:0];
         div_q_ff   <= {div_q_ff[62:0], dv_geq};
      end
   end

   logic [64:0] acc_sum;
   assign acc_sum = {1'b0, energy_sum_ff} + {1'b0, term_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_sum_ff <= '0;
      end else if (cmd.accum) begin
         energy_sum_ff <= acc_sum[64] ? {64{1'b1}} : acc_sum[63:0];
      end else if (cmd.out_load && last_ff) begin
         energy_sum_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_outside) begin
         outside_ff <= status.outside;
      end
   end

   assign status.outside = !rbig && (rsq_ff > rr_ff);
   assign status.last = last_ff;

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_acc_dx        <= outside_ff ? dx_ff : '0;
         rsp_acc_dy        <= outside_ff ? dy_ff : '0;
         rsp_acc_dz        <= outside_ff ? dz_ff : '0;
         rsp_outside_shell <= outside_ff;
         rsp_batch_energy  <= last_ff ? energy_ff : '0;
         rsp_batch_done    <= last_ff;
      end
   end

endmodule

[sim/ssfe_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the shell block, predicts each result beat from the
// accepted point beats and the register writes, and counts mismatches.
module ssfe_checker import ssfe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [CSR_DW-1:0]  csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               req_last_point,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_acc_dx,
   input  logic signed [31:0] rsp_acc_dy,
   input  logic signed [31:0] rsp_acc_dz,
   input  logic               rsp_outside_shell,
   input  logic [62:0]        rsp_batch_energy,
   input  logic               rsp_batch_done,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic        outside;
      logic [62:0] energy;
      logic        done;
   } shell_result_type;

   shell_result_type expected_q[$];

   logic [30:0] radius0_r;
   logic [31:0] start_time_r;
   logic [31:0] shrink_rate_r;
   logic [30:0] strength_r;
   logic [31:0] current_time_r;
   logic [63:0] overshoot_sum;

   assign pending_count = expected_q.size();

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Opposite-signed, saturated increment for one coordinate.
   function automatic logic [31:0] push_back(input logic [63:0] fac, input logic signed [31:0] p);
      logic [63:0] mag;
      logic [63:0] m;
      mag = p < 0 ? 64'(-64'(p)) : 64'(p);
      m = (fac * mag) >> 16;
      if (p > 0) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
      return (m >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   function automatic logic [62:0] batch_energy_of(input logic [63:0] sum);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] v;
      lo = 64'(strength_r) * {32'd0, sum[31:0]};
      hi = 64'(strength_r) * {32'd0, sum[63:32]};
      if (hi >= 64'd1 << 48) return '1;
      v = (hi << 15) + (lo >> 17);
      return v[63] ? '1 : v[62:0];
   endfunction

   task automatic predict_point();
      logic signed [63:0] dt;
      logic signed [63:0] prod;
      logic signed [63:0] sh;
      logic signed [63:0] r;
      logic [63:0] rabs;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] az;
      logic [63:0] rsq;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] fac;
      logic [63:0] term;
      shell_result_type res;
      dt = 64'(signed'(current_time_r)) - 64'(signed'(start_time_r));
      prod = 64'(signed'(shrink_rate_r)) * dt;
      sh = prod >>> 16;
      r = 64'(radius0_r) - sh;
      rabs = r < 0 ? -r : r;
      ax = req_pos_x < 0 ? 64'(-64'(req_pos_x)) : 64'(req_pos_x);
      ay = req_pos_y < 0 ? 64'(-64'(req_pos_y)) : 64'(req_pos_y);
      az = req_pos_z < 0 ? 64'(-64'(req_pos_z)) : 64'(req_pos_z);
      rsq = ax * ax + ay * ay + az * az;
      res = '0;
      res.outside = (rabs < 64'd1 << 32) && (rsq > rabs * rabs);
      if (res.outside) begin
         s = int_sqrt(rsq);
         d = s - r;
         fac = (64'(strength_r) * d) / s;
         term = (d >= 64'd1 << 32) ? '1 : d * d;
         res.dx = push_back(fac, req_pos_x);
         res.dy = push_back(fac, req_pos_y);
         res.dz = push_back(fac, req_pos_z);
         overshoot_sum = (overshoot_sum > ~term) ? '1 : overshoot_sum + term;
      end
      res.done = req_last_point;
      if (req_last_point) begin
         res.energy = batch_energy_of(overshoot_sum);
         overshoot_sum = 0;
      end
      expected_q.push_back(res);
   endtask

   task automatic compare_result();
      shell_result_type exp_r;
      if (expected_q.size() == 0) begin
         $error("result beat with no point outstanding");
         fail_count++;
         return;
      end
      exp_r = expected_q.pop_front();
      if (rsp_acc_dx !== exp_r.dx) begin
         $error("acc_dx expected %h actual %h", exp_r.dx, rsp_acc_dx); fail_count++;
      end
      if (rsp_acc_dy !== exp_r.dy) begin
         $error("acc_dy expected %h actual %h", exp_r.dy, rsp_acc_dy); fail_count++;
      end
      if (rsp_acc_dz !== exp_r.dz) begin
         $error("acc_dz expected %h actual %h", exp_r.dz, rsp_acc_dz); fail_count++;
      end
      if (rsp_outside_shell !== exp_r.outside) begin
         $error("outside_shell expected %b actual %b", exp_r.outside, rsp_outside_shell);
         fail_count++;
      end
      if (rsp_batch_energy !== exp_r.energy) begin
         $error("batch_energy expected %h actual %h", exp_r.energy, rsp_batch_energy);
         fail_count++;
      end
      if (rsp_batch_done !== exp_r.done) begin
         $error("batch_done expected %b actual %b", exp_r.done, rsp_batch_done);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         radius0_r <= 31'd65536;
         start_time_r <= 0;
         shrink_rate_r <= 0;
         strength_r <= 31'd65536;
         current_time_r <= 0;
         overshoot_sum = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_result();
         if (req_valid && req_ready) predict_point();
         if (csr_we) begin
            case (csr_addr)
               CSR_RADIUS0: begin
                  radius0_r <= csr_wdata[30:0];
               end
               CSR_START_TIME: begin
                  start_time_r <= csr_wdata;
               end
               CSR_SHRINK_RATE: begin
                  shrink_rate_r <= csr_wdata;
               end
               CSR_STRENGTH: begin
                  strength_r <= csr_wdata[30:0];
               end
               CSR_CURRENT_TIME: begin
                  current_time_r <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

[sim/tb_shrinking_shell_force_energy.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the shell block. The checker beside the block does
// all the prediction; this module only drives beats, registers and handshakes.
module tb_shrinking_shell_force_energy;
   import ssfe_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_we = 0;
   logic [CSR_AW-1:0]  csr_addr = '0;
   logic [CSR_DW-1:0]  csr_wdata = '0;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_pos_x = 0;
   logic signed [31:0] req_pos_y = 0;
   logic signed [31:0] req_pos_z = 0;
   logic               req_last_point = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_acc_dx;
   logic signed [31:0] rsp_acc_dy;
   logic signed [31:0] rsp_acc_dz;
   logic               rsp_outside_shell;
   logic [62:0]        rsp_batch_energy;
   logic               rsp_batch_done;
   int                 fail_count;
   int                 pending_count;
   bit                 calm_phase = 0;
   int                 stall_left = 0;

   always #6 clock = ~clock;

   shrinking_shell_force_energy DUT (.*);
   ssfe_checker checker_i (.*);

   // The receiver stalls in random bursts until the calm phase at the end.
   always @(posedge clock) begin
      if (reset || calm_phase) begin
         rsp_ready <= 1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
      end else if (rsp_ready && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1;
      end
   end

   // Leaves csr_we high so that writes can follow back to back; the caller drops it.
   task automatic write_reg(input csr_idx_type idx, input logic [31:0] value);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Waits until every predicted result is back and the block has gone quiet.
   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   // Sends one point beat; valid stays high until the block takes it.
   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Coordinates mostly near the shell so that both sides of it are hit,
   // with an occasional full-range value.
   function automatic logic [31:0] near_coord(input int span);
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = 0;
         default: v = $urandom_range(0, span);
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   task automatic set_shell(input logic [31:0] r0, input logic [31:0] t0,
                            input logic [31:0] rate, input logic [31:0] c,
                            input logic [31:0] t);
      write_reg(CSR_RADIUS0, r0);
      write_reg(CSR_START_TIME, t0);
      write_reg(CSR_SHRINK_RATE, rate);
      write_reg(CSR_STRENGTH, c);
      write_reg(CSR_CURRENT_TIME, t);
   endtask

   initial begin
      int span;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed beats at reset defaults: origin, inside, outside, extremes.
      send_point(0, 0, 0, 0);
      send_point(32'h0000_8000, 0, 0, 0);
      send_point(32'h0002_0000, 0, 0, 0);
      send_point(0, 32'hFFFE_0000, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      send_point(32'h0001_0000, 0, 0, 1);
      send_point(32'h0000_0001, 32'hFFFF_FFFF, 0, 1);
      drain();

      // Negative radius of huge magnitude and huge strength; every point is inside.
      set_shell(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      csr_we <= 0;
      send_point(32'h0003_0000, 32'h0000_0001, 32'hFFFF_0000, 0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
      drain();
      // Radius magnitude far beyond 2^32 raw: everything inside. Unused index is ignored.
      set_shell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000);
      write_reg(csr_idx_type'(3'd7), 32'hFFFF_FFFF);
      csr_we <= 0;
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
      send_point(32'h0000_0005, 32'h0, 32'h0, 1);
      drain();
      set_shell(32'h0, 0, 0, 32'h7FFF_FFFF, 0);
      csr_we <= 0;
      send_point(32'h0000_0001, 0, 0, 0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1);
      drain();

      // Random phases with random shell settings; batches of a few points.
      for (int ph = 0; ph < 25; ph++) begin
         set_shell($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0000_4000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0008_0000));
         csr_we <= 0;
         span = $urandom_range(0, 1) ? 32'h0004_0000 : 32'h0040_0000;
         if (ph == 24) calm_phase = 1;
         for (int n = 0; n < 50; n++)
            send_point(near_coord(span), near_coord(span), near_coord(span),
                       $urandom_range(0, 5) == 0 || n == 49);
         drain();
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
src/ssfe_pkg.sv
src/ssfe_ctrl.sv
src/ssfe_dp.sv
src/shrinking_shell_force_energy.sv
sim/ssfe_checker.sv
sim/tb_shrinking_shell_force_energy.sv
